// File: rtl/window_min_max_height_query_core_macros.svh
// Assertion macros for the height query core.
// Each macro expects clk and rst in scope where it is used.
`ifndef WINDOW_MIN_MAX_HEIGHT_QUERY_CORE_MACROS_SVH
`define WINDOW_MIN_MAX_HEIGHT_QUERY_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define WMMHQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define WMMHQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/wmmhq_pkg.sv
package wmmhq_pkg;

  // Default map limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Field widths
  localparam int HEIGHT_W  = 16;
  localparam int MAP_REG_W = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [MAP_REG_W-1:0] MAP_RESET = 9'd256;

  // Register indexes (paddr bit 2)
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_QUERY = 2'd1;
  localparam logic [1:0] ST_OOB   = 2'd2;

  localparam logic [HEIGHT_W-1:0] EMPTY_MIN = 16'hFFFF;
  localparam logic [HEIGHT_W-1:0] EMPTY_MAX = 16'h0000;

  typedef struct packed {
    logic                op;
    logic [15:0]         address;
    logic [HEIGHT_W-1:0] value;
    logic [7:0]          x_start;
    logic [7:0]          z_start;
    logic [8:0]          size_x;
    logic [8:0]          size_z;
  } wmmhq_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] min_height;
    logic [HEIGHT_W-1:0] max_height;
    logic [1:0]          status;
  } wmmhq_result_t;

  typedef struct packed {
    logic [MAP_REG_W-1:0] map_width;
    logic [MAP_REG_W-1:0] map_height;
  } wmmhq_map_t;

  typedef struct packed {
    logic busy;
    logic scanning;
  } wmmhq_stat_t;

endpackage

// File: rtl/wmmhq_ram.sv
module wmmhq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/wmmhq_cfg.sv
module wmmhq_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wmmhq_pkg::PADDR_W-1:0]      paddr,
  input  logic [wmmhq_pkg::PDATA_W-1:0]      pwdata,
  output logic [wmmhq_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready,
  output wmmhq_pkg::wmmhq_map_t              map
);
  import wmmhq_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Update map size registers on a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      map.map_width  <= MAP_RESET;
      map.map_height <= MAP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAP_WIDTH:  map.map_width  <= pwdata[MAP_REG_W-1:0];
        REG_MAP_HEIGHT: map.map_height <= pwdata[MAP_REG_W-1:0];
        default:        ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_MAP_WIDTH:  prdata = PDATA_W'(map.map_width);
      REG_MAP_HEIGHT: prdata = PDATA_W'(map.map_height);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/wmmhq_seq.sv
module wmmhq_seq #(
  parameter int MAX_WIDTH  = wmmhq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmmhq_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  wmmhq_pkg::wmmhq_map_t                        map,
  input  logic                                         item_valid,
  output logic                                         item_stall,
  input  wmmhq_pkg::wmmhq_item_t                       item,
  output logic                                         result_valid,
  input  logic                                         result_stall,
  output wmmhq_pkg::wmmhq_result_t                     result,
  output logic                                         ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      ram_waddr,
  output logic [wmmhq_pkg::HEIGHT_W-1:0]               ram_wdata,
  output logic                                         ram_re,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      ram_raddr,
  input  logic [wmmhq_pkg::HEIGHT_W-1:0]               ram_rdata,
  output wmmhq_pkg::wmmhq_stat_t                       stat
);
  import wmmhq_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = WW + HW;
  localparam int PW = 8 + WW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_DISP  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state, state_next;
  wmmhq_item_t         cur;
  wmmhq_result_t       res;
  logic [WW-1:0]       w_sel, w_eff;
  logic [HW-1:0]       h_sel, h_eff;
  logic [RW-1:0]       area;
  logic [PW-1:0]       prod;
  logic [AW-1:0]       addr, row_base, row_start;
  logic [8:0]          col, row;
  logic                rd_v;
  logic [HEIGHT_W-1:0] lo, hi, lo_next, hi_next;
  logic                wr_ok, q_oob, q_empty, last_col, last_row, out_free;

  // Clamp the map size registers to the legal range
  always_comb begin
    if (map.map_width == '0) begin
      w_sel = WW'(1);
    end else if (32'(map.map_width) > MAX_WIDTH) begin
      w_sel = WW'(MAX_WIDTH);
    end else begin
      w_sel = WW'(map.map_width);
    end
    if (map.map_height == '0) begin
      h_sel = HW'(1);
    end else if (32'(map.map_height) > MAX_HEIGHT) begin
      h_sel = HW'(MAX_HEIGHT);
    end else begin
      h_sel = HW'(map.map_height);
    end
  end

  // Decode the captured transaction
  assign wr_ok     = 32'(cur.address) < 32'(area);
  assign q_oob     = (32'(cur.x_start) + 32'(cur.size_x) > 32'(w_eff)) ||
                     (32'(cur.z_start) + 32'(cur.size_z) > 32'(h_eff));
  assign q_empty   = (cur.size_x == '0) || (cur.size_z == '0);
  assign row_start = AW'(prod + PW'(cur.x_start));
  assign last_col  = col == cur.size_x - 9'd1;
  assign last_row  = row == cur.size_z - 9'd1;
  assign out_free  = !result_valid || !result_stall;

  // Fold the returning read data into the running min and max
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rd_v) begin
      if (ram_rdata < lo) lo_next = ram_rdata;
      if (ram_rdata > hi) hi_next = ram_rdata;
    end
  end

  // Memory access: writes only in dispatch, reads only while scanning
  assign ram_we    = (state == S_DISP) && (cur.op == OP_WRITE) && wr_ok;
  assign ram_waddr = AW'(cur.address);
  assign ram_wdata = cur.value;
  assign ram_re    = state == S_SCAN;
  assign ram_raddr = addr;

  assign item_stall     = state != S_IDLE;
  assign stat.busy      = state != S_IDLE;
  assign stat.scanning  = state == S_SCAN;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_PREP;
      S_PREP:  state_next = S_DISP;
      S_DISP:  begin
        if (cur.op == OP_QUERY && !q_oob && !q_empty) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN:  if (last_col && last_row) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= state == S_SCAN;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item_valid) cur <= item;
      end
      S_PREP: begin
        w_eff <= w_sel;
        h_eff <= h_sel;
        area  <= RW'(w_sel) * RW'(h_sel);
        prod  <= PW'(cur.z_start) * PW'(w_sel);
      end
      S_DISP: begin
        lo       <= EMPTY_MIN;
        hi       <= EMPTY_MAX;
        addr     <= row_start;
        row_base <= row_start;
        col      <= '0;
        row      <= '0;
        res.min_height <= EMPTY_MIN;
        res.max_height <= EMPTY_MAX;
        if (cur.op == OP_WRITE) begin
          res.status <= wr_ok ? ST_WRITE : ST_OOB;
        end else begin
          res.status <= q_oob ? ST_OOB : ST_QUERY;
        end
      end
      S_SCAN: begin
        lo <= lo_next;
        hi <= hi_next;
        if (last_col) begin
          // Step to the start of the next row
          row_base <= row_base + AW'(w_eff);
          addr     <= row_base + AW'(w_eff);
          col      <= '0;
          row      <= row + 9'd1;
        end else begin
          addr <= addr + AW'(1);
          col  <= col + 9'd1;
        end
      end
      S_DRAIN: begin
        res.min_height <= lo_next;
        res.max_height <= hi_next;
        res.status     <= ST_QUERY;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register: hold until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result <= res;
    end
  end

endmodule

// File: rtl/window_min_max_height_query_core.sv
// Channel | Dir | Handshake                     | Payload
// config  | in  | psel/penable/pwrite, pready=1 | map_width, map_height
// item    | in  | item_valid / item_stall       | wmmhq_item_t
// result  | out | result_valid / result_stall   | wmmhq_result_t
//
// A write, an empty query or a flagged query steps through prepare, dispatch and done before
// the next acceptance. A non-empty in-bounds query also scans, issuing one store read
// per covered entry through the single read port of the height RAM, and then drains.
// Reset clears control state only; the height store holds garbage until written.
// The next item is accepted while a finished result waits in the output register;
// a stalled result holds the sequencer in its final state until taken.
`include "window_min_max_height_query_core_macros.svh"

module window_min_max_height_query_core #(
  parameter int MAX_WIDTH  = wmmhq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmmhq_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wmmhq_pkg::PADDR_W-1:0]   paddr,
  input  logic [wmmhq_pkg::PDATA_W-1:0]   pwdata,
  output logic [wmmhq_pkg::PDATA_W-1:0]   prdata,
  output logic                            pready,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  wmmhq_pkg::wmmhq_item_t          item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output wmmhq_pkg::wmmhq_result_t        result
);
  import wmmhq_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  wmmhq_map_t          map;
  wmmhq_stat_t         stat;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

  wmmhq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map     (map)
  );

  wmmhq_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .map          (map),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .stat         (stat)
  );

  wmmhq_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Non-query results always carry the empty min and max
  `WMMHQ_ASSERT_IMPL(a_empty_fields, result_valid && result.status != ST_QUERY, result.min_height == EMPTY_MIN && result.max_height == EMPTY_MAX, "flagged or write result with data")
  // No store write may land during a scan
  `WMMHQ_ASSERT_IMPL(a_no_write_in_scan, ram_we, stat.busy && !stat.scanning, "store write outside dispatch")
  // Input side stays closed while the sequencer works
  `WMMHQ_ASSERT_IMPL(a_stall_when_busy, stat.busy, item_stall, "item accepted while busy")

endmodule

// File: tb/window_min_max_height_query_core_checker.sv
module window_min_max_height_query_core_checker #(
  parameter int MAX_WIDTH  = wmmhq_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmmhq_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wmmhq_pkg::PADDR_W-1:0] paddr,
  input  logic [wmmhq_pkg::PDATA_W-1:0] pwdata,
  input  logic                          pready,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  wmmhq_pkg::wmmhq_item_t        item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  wmmhq_pkg::wmmhq_result_t      result,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wmmhq_pkg::*;

  // Shadow copy of the height RAM and the two map registers
  logic [HEIGHT_W-1:0]  heights [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [MAP_REG_W-1:0] cols_reg;
  logic [MAP_REG_W-1:0] rows_reg;
  wmmhq_result_t        answers_due [$];
  wmmhq_result_t        want;
  int                   errors = 0;

  task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
    errors++;
    if (errors <= 60)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // Out-of-range register values act as the nearest legal size
  function automatic int unsigned clamp_dim(logic [MAP_REG_W-1:0] r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  // Apply one transaction to the shadow store and work out its answer
  function automatic wmmhq_result_t answer_for(wmmhq_item_t it);
    int unsigned   w;
    int unsigned   h;
    int unsigned   row;
    int unsigned   col;
    int unsigned   idx;
    wmmhq_result_t r;
    w = clamp_dim(cols_reg, MAX_WIDTH);
    h = clamp_dim(rows_reg, MAX_HEIGHT);
    r.min_height = EMPTY_MIN;
    r.max_height = EMPTY_MAX;
    if (it.op == OP_WRITE) begin
      if (it.address < w * h) begin
        heights[it.address] = it.value;
        r.status = ST_WRITE;
      end else begin
        r.status = ST_OOB;
      end
    end else if (it.x_start + it.size_x > w || it.z_start + it.size_z > h) begin
      r.status = ST_OOB;
    end else begin
      // Scan the window row by row; an empty window keeps the start values
      for (row = 0; row < it.size_z; row++) begin
        for (col = 0; col < it.size_x; col++) begin
          idx = (it.z_start + row) * w + it.x_start + col;
          if (heights[idx] < r.min_height) r.min_height = heights[idx];
          if (heights[idx] > r.max_height) r.max_height = heights[idx];
        end
      end
      r.status = ST_QUERY;
    end
    return r;
  endfunction

  // Track register writes, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    if (rst) begin
      cols_reg = MAP_RESET;
      rows_reg = MAP_RESET;
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAP_WIDTH) cols_reg = pwdata[MAP_REG_W-1:0];
        else rows_reg = pwdata[MAP_REG_W-1:0];
      end
      if (result_valid && !result_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing pending, status", 0, result.status);
        end else begin
          want = answers_due.pop_front();
          if (result.min_height !== want.min_height)
            report_mismatch("min_height", want.min_height, result.min_height);
          if (result.max_height !== want.max_height)
            report_mismatch("max_height", want.max_height, result.max_height);
          if (result.status !== want.status)
            report_mismatch("status", want.status, result.status);
        end
      end
      if (item_valid && !item_stall) answers_due.push_back(answer_for(item));
    end
    fail_count <= errors;
    pending <= answers_due.size();
  end

endmodule

// File: tb/window_min_max_height_query_core_tb.sv
module window_min_max_height_query_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmmhq_pkg::*;

  localparam int STORE_N     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int ITEM_GOAL   = 1000;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 16;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [PADDR_W-1:0]   paddr        = '0;
  logic [PDATA_W-1:0]   pwdata       = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  wmmhq_item_t          item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  wmmhq_result_t        result;
  int                   fail_count;
  int                   pending;

  // Stimulus-side view of the map and of which entries hold a known height
  bit                   written [STORE_N];
  int unsigned          cols_eff = MAX_WIDTH_DEF;
  int unsigned          rows_eff = MAX_HEIGHT_DEF;
  int unsigned          sent     = 0;
  int unsigned          cycles   = 0;
  bit                   calm     = 1'b0;
  bit                   hold_req = 1'b0;

  int unsigned map_cols_seq [8] = '{16, 1, 0, 511, 256, 1, 300, 37};
  int unsigned map_rows_seq [8] = '{16, 1, 0, 3, 1, 256, 40, 200};

  window_min_max_height_query_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  window_min_max_height_query_core_checker u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned dim_of(int unsigned r, int unsigned lim);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  // Random content in every field but op, which starts as a write; callers override the ones that matter
  function automatic wmmhq_item_t noise_item();
    wmmhq_item_t it;
    it.op      = OP_WRITE;
    it.address = 16'($urandom());
    it.value   = 16'($urandom());
    it.x_start = 8'($urandom());
    it.z_start = 8'($urandom());
    it.size_x  = 9'($urandom_range(0, 256));
    it.size_z  = 9'($urandom_range(0, 256));
    return it;
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic push_item(wmmhq_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic store_height(int unsigned addr, int unsigned val);
    wmmhq_item_t it;
    it = noise_item();
    it.op = OP_WRITE;
    it.address = 16'(addr);
    it.value = 16'(val);
    push_item(it);
    if (addr < cols_eff * rows_eff) written[addr] = 1'b1;
  endtask

  // Fill any never-written entry under an in-bounds window, then query it
  task automatic ask_window(int unsigned x0, int unsigned z0, int unsigned sx,
                            int unsigned sz);
    int unsigned r;
    int unsigned c;
    int unsigned a;
    wmmhq_item_t it;
    if (x0 + sx <= cols_eff && z0 + sz <= rows_eff) begin
      for (r = 0; r < sz; r++) begin
        for (c = 0; c < sx; c++) begin
          a = (z0 + r) * cols_eff + x0 + c;
          if (!written[a]) store_height(a, $urandom_range(0, 65535));
        end
      end
    end
    it = noise_item();
    it.op = OP_QUERY;
    it.x_start = 8'(x0);
    it.z_start = 8'(z0);
    it.size_x = 9'(sx);
    it.size_z = 9'(sz);
    push_item(it);
  endtask

  // Drop valid and wait until every answer is back and the core is quiet
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [MAP_REG_W-1:0] val);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[MAP_REG_W-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_map(int unsigned w, int unsigned h);
    write_reg(REG_MAP_WIDTH, MAP_REG_W'(w));
    write_reg(REG_MAP_HEIGHT, MAP_REG_W'(h));
    cols_eff = dim_of(w, MAX_WIDTH_DEF);
    rows_eff = dim_of(h, MAX_HEIGHT_DEF);
  endtask

  // Mostly writes and queries near the origin, plus wide rows and noise
  task automatic run_phase(int unsigned n);
    int unsigned roll;
    int unsigned lx;
    int unsigned lz;
    int unsigned sx;
    int unsigned sz;
    int unsigned x0;
    int unsigned z0;
    int unsigned val;
    lx = (cols_eff < 16) ? cols_eff : 16;
    lz = (rows_eff < 16) ? rows_eff : 16;
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        case ($urandom_range(0, 9))
          0: val = 0;
          1: val = 65535;
          default: val = $urandom_range(0, 65535);
        endcase
        if (roll < 35)
          store_height($urandom_range(0, lz - 1) * cols_eff + $urandom_range(0, lx - 1), val);
        else
          store_height($urandom_range(0, 65535), val);
      end else if (roll < 85) begin
        sx = $urandom_range(0, (lx < 8) ? lx : 8);
        sz = $urandom_range(0, (lz < 8) ? lz : 8);
        ask_window($urandom_range(0, lx - sx + 1), $urandom_range(0, lz - sz + 1), sx, sz);
      end else if (roll < 86) begin
        ask_window(0, $urandom_range(0, (lz < 4) ? lz - 1 : 3), cols_eff, 1);
      end else begin
        x0 = $urandom_range(0, 255);
        z0 = $urandom_range(0, 255);
        sx = $urandom_range(0, 256);
        sz = $urandom_range(0, 256);
        // skip noise that would land in bounds over a large window
        if (!(x0 + sx <= cols_eff && z0 + sz <= rows_eff && sx * sz > 16))
          ask_window(x0, z0, sx, sz);
      end
    end
  endtask

  // Result side: random stalls, one long hold-off once requested
  initial begin : sink
    int unsigned span;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        span = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        span = pick_gap();
      end
      if (span != 0) begin
        result_stall <= 1'b1;
        repeat (span) @(posedge clk);
        result_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Corner values under the reset map size
    store_height(0, 0);
    store_height(1, 65535);
    store_height(256, 16'h8001);
    store_height(257, 16'h7FFE);
    store_height(65535, 16'h5A5A);
    ask_window(0, 0, 2, 2);
    ask_window(255, 255, 1, 1);
    ask_window(1, 0, 1, 2);
    ask_window(7, 9, 0, 4);
    ask_window(7, 9, 4, 0);
    ask_window(0, 0, 0, 0);
    ask_window(255, 0, 2, 1);
    ask_window(0, 255, 1, 2);
    ask_window(1, 0, 256, 1);
    ask_window(0, 250, 0, 10);
    drain();

    // Zero width acts as one column, oversized height as the maximum
    set_map(0, 300);
    store_height(256, 1);
    store_height(65535, 2);
    ask_window(0, 0, 1, 256);
    ask_window(0, 0, 2, 1);
    drain();

    // Single row map: full-width window and writes past the end
    set_map(256, 1);
    ask_window(0, 0, 256, 1);
    store_height(256, 3);
    ask_window(0, 0, 1, 2);
    drain();

    set_map(511, 511);
    hold_req = 1'b1;
    k = 0;
    while (sent < ITEM_GOAL) begin
      run_phase($urandom_range(60, 120));
      drain();
      if (k < 8) set_map(map_cols_seq[k], map_rows_seq[k]);
      else set_map($urandom_range(0, 511), $urandom_range(0, 511));
      k++;
    end
    run_phase(40);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
